// ===== hdl/dtt_pkg.sv =====
// Shared types and constants of the depth-to-time trace resampler.
// Used by dtt_front, dtt_fifo, dtt_back and depth_to_time_trace_resampler.
// No dependencies.
package dtt_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_REF_VEL   = 2'd0;
  localparam logic [1:0] CFG_UNDEF_VEL = 2'd1;
  localparam logic [1:0] CFG_TRACE_LEN = 2'd2;

  // Run length field width; holds up to 127 samples
  localparam int RUN_W = 7;

  // Configuration register set
  typedef struct packed {
    logic [15:0] ref_vel;
    logic [15:0] undef_vel;
    logic [12:0] trace_len;
  } cfg_t;

  // One run of time samples to emit for one depth cell
  typedef struct packed {
    logic [11:0]      lo;
    logic [RUN_W-1:0] count;
    logic             present;
    logic [15:0]      tag;
    logic             clipped;
  } run_t;

endpackage

// ===== hdl/dtt_fifo.sv =====
// Two-entry queue of run descriptors between the front and back parts.
// Depends on dtt_pkg (run_t).
module dtt_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtt_pkg::run_t push_data,
  output logic          full,
  input  logic          pop,
  output dtt_pkg::run_t pop_data,
  output logic          empty
);

  dtt_pkg::run_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("run queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("run queue read while empty");
`endif

endmodule

// ===== hdl/dtt_front.sv =====
// Front part: accepts depth cells, divides reference by cell (or undefined)
// velocity one quotient bit per cycle, advances travel time, queues a run.
// Depends on dtt_pkg (cfg_t, run_t, RUN_W).
module dtt_front #(
  parameter int TRACE_DEPTH = 4096,
  parameter int MAX_RUN     = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  dtt_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_start,
  input  logic          in_present,
  input  logic [15:0]   in_velocity,
  input  logic [15:0]   in_tag,
  output logic          push,
  output dtt_pkg::run_t push_run,
  input  logic          full
);

  localparam int DW    = 16 + FRAC_BITS;
  localparam int SW    = ((DW > 32) ? DW : 32) + 1;
  localparam int CNT_W = $clog2(DW);
  localparam logic [12:0] EFF_CAP   = 13'((TRACE_DEPTH < 4096) ? TRACE_DEPTH : 4096);
  localparam logic [32:0] HALF      = 33'(1) << (FRAC_BITS - 1);
  localparam logic [12:0] RUN_LIMIT = 13'(MAX_RUN);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIV  = 4'b0010,
    F_ACC  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t          state;
  logic [31:0]      acc;
  logic [12:0]      next_sample;
  logic [15:0]      divisor;
  logic [15:0]      rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] step;
  logic             present;
  logic [15:0]      tag;

  logic [15:0] vel_sel;
  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_sub;
  logic [SW-1:0] sum;
  logic [32:0] lim_sum;
  logic [32:0] limit;
  logic [12:0] eff;
  logic [12:0] hi;
  logic [12:0] nxt;
  logic [12:0] count_full;
  logic        clipped;
  logic [dtt_pkg::RUN_W-1:0] count;

  assign in_ready = (state == F_IDLE);

  // Select the velocity; a zero divisor acts as one
  always_comb begin
    vel_sel = in_present ? in_velocity : cfg.undef_vel;
    if (vel_sel == 16'd0) begin
      vel_sel = 16'd1;
    end
  end

  // One restoring division step
  assign rem_sh  = {rem, quo[DW-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Saturating travel time sum
  assign sum = SW'(acc) + SW'(quo);

  // Rounded index, clipped range and run length
  always_comb begin
    lim_sum = {1'b0, acc} + HALF;
    limit   = lim_sum >> FRAC_BITS;
    nxt     = (limit > 33'd8191) ? 13'd8191 : limit[12:0];
    eff     = (cfg.trace_len < EFF_CAP) ? cfg.trace_len : EFF_CAP;
    hi      = (limit < {20'd0, eff}) ? limit[12:0] : eff;
    count_full = (hi > next_sample) ? (hi - next_sample) : 13'd0;
    clipped = (count_full > RUN_LIMIT);
    count   = clipped ? dtt_pkg::RUN_W'(MAX_RUN) : count_full[dtt_pkg::RUN_W-1:0];
  end

  assign push             = (state == F_PUSH) && (count != '0) && !full;
  assign push_run.lo      = next_sample[11:0];
  assign push_run.count   = count;
  assign push_run.present = present;
  assign push_run.tag     = tag;
  assign push_run.clipped = clipped;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          divisor <= vel_sel;
          rem     <= 16'd0;
          quo     <= {cfg.ref_vel, FRAC_BITS'(0)};
          step    <= CNT_W'(DW - 1);
          present <= in_present;
          tag     <= in_present ? in_tag : 16'd0;
        end
      end
      F_DIV: begin
        rem  <= ge ? rem_sub[15:0] : rem_sh[15:0];
        quo  <= {quo[DW-2:0], ge};
        step <= step - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Sequence one cell and hold the trace state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      acc         <= 32'd0;
      next_sample <= 13'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            if (in_start) begin
              acc         <= 32'd0;
              next_sample <= 13'd0;
            end
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (step == '0) begin
            state <= F_ACC;
          end
        end
        F_ACC: begin
          acc   <= (sum[SW-1:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (count == '0 || !full) begin
            next_sample <= nxt;
            state       <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_bounds: assert property (@(posedge clk) disable iff (rst)
      push |-> (push_run.count != '0) && (push_run.count <= dtt_pkg::RUN_W'(MAX_RUN)))
    else $error("queued run length out of range");
  a_clip_full: assert property (@(posedge clk) disable iff (rst)
      (push && push_run.clipped) |-> (push_run.count == dtt_pkg::RUN_W'(MAX_RUN)))
    else $error("clipped run not at full length");
`endif

endmodule

// ===== hdl/dtt_back.sv =====
// Back part: takes run descriptors from the queue and emits one sample
// transaction per cycle when out_ready allows, via a registered output.
// Depends on dtt_pkg (run_t, RUN_W).
module dtt_back (
  input  logic          clk,
  input  logic          rst,
  output logic          pop,
  input  dtt_pkg::run_t pop_run,
  input  logic          empty,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   out_index,
  output logic          out_present,
  output logic [15:0]   out_tag,
  output logic          out_last,
  output logic          out_clipped
);

  logic                      busy;
  logic [11:0]               cur_idx;
  logic [dtt_pkg::RUN_W-1:0] cur_rem;
  logic                      cur_present;
  logic [15:0]               cur_tag;
  logic                      cur_clipped;
  logic                      slot_free;
  logic                      emit;

  assign slot_free = !out_valid || out_ready;
  assign emit      = busy && slot_free;
  assign pop       = !busy && !empty;

  // Load a run and step through its samples
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_idx     <= pop_run.lo;
      cur_present <= pop_run.present;
      cur_tag     <= pop_run.tag;
      cur_clipped <= pop_run.clipped;
    end else if (emit) begin
      cur_idx <= cur_idx + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cur_rem <= '0;
    end else if (pop) begin
      busy    <= 1'b1;
      cur_rem <= pop_run.count;
    end else if (emit) begin
      cur_rem <= cur_rem - dtt_pkg::RUN_W'(1);
      if (cur_rem == dtt_pkg::RUN_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_index   <= cur_idx;
      out_present <= cur_present;
      out_tag     <= cur_tag;
      out_last    <= (cur_rem == dtt_pkg::RUN_W'(1));
      out_clipped <= cur_clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

`ifndef SYNTHESIS
  a_busy_rem: assert property (@(posedge clk) disable iff (rst) busy |-> (cur_rem != '0))
    else $error("active run with no samples left");
`endif

endmodule

// ===== hdl/depth_to_time_trace_resampler.sv =====
// Depth-to-time trace resampler: depth cells in, time samples out.
// A cell is accepted only once the bit-serial divider and the run push of the last
// one are done, and the push waits while the run queue is full; samples leave at
// one per cycle within a run while m_tready allows, overlapping the next divide.
// Reset (rst, synchronous, high) loads the register defaults, clears travel
// time, the run queue and the output stage.
module depth_to_time_trace_resampler #(
  parameter int TRACE_DEPTH = 4096,
  parameter int MAX_RUN     = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // depth cell stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] cell_velocity, [31:16] content_tag
  input  logic [1:0]  s_tuser,   // [0] trace_start, [1] cell_present
  // time sample stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] sample_index, [27:12] out_tag, [31:28] zero
  output logic [1:0]  m_tuser,   // [0] out_present, [1] run_clipped
  output logic        m_tlast    // run_last
);

  dtt_pkg::cfg_t cfg;
  dtt_pkg::run_t push_run;
  dtt_pkg::run_t pop_run;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic [11:0]   sample_index;
  logic [15:0]   out_tag;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_vel   <= 16'd6000;
      cfg.undef_vel <= 16'd1500;
      cfg.trace_len <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        dtt_pkg::CFG_REF_VEL:   cfg.ref_vel   <= cfg_data;
        dtt_pkg::CFG_UNDEF_VEL: cfg.undef_vel <= cfg_data;
        dtt_pkg::CFG_TRACE_LEN: cfg.trace_len <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  dtt_front #(
    .TRACE_DEPTH (TRACE_DEPTH),
    .MAX_RUN     (MAX_RUN),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_start    (s_tuser[0]),
    .in_present  (s_tuser[1]),
    .in_velocity (s_tdata[15:0]),
    .in_tag      (s_tdata[31:16]),
    .push        (push),
    .push_run    (push_run),
    .full        (full)
  );

  dtt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_run),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_run),
    .empty     (empty)
  );

  dtt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop         (pop),
    .pop_run     (pop_run),
    .empty       (empty),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_index   (sample_index),
    .out_present (m_tuser[0]),
    .out_tag     (out_tag),
    .out_last    (m_tlast),
    .out_clipped (m_tuser[1])
  );

  assign m_tdata = {4'd0, out_tag, sample_index};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for depth_to_time_trace_resampler: streams depth cells,
// predicts every time sample in a small scoreboard class and checks them in order.
// Depends on dtt_pkg and the resampler RTL only.
module testbench;

  localparam int TRACE_DEPTH   = 4096;
  localparam int MAX_RUN       = 64;
  localparam int FRAC_BITS     = 16;
  // idle wait before a register write; lets the divider finish the last cell
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [11:0] idx;
    logic        present;
    logic [15:0] tag;
    logic        last;
    logic        clipped;
  } time_sample_t;

  // Predicts the time samples of each depth cell and checks the ones that arrive
  class resampled_trace;
    logic [15:0]  ref_vel;
    logic [15:0]  undef_vel;
    logic [12:0]  trace_len;
    logic [31:0]  travel_acc;
    logic [12:0]  next_idx;
    time_sample_t due_samples[$];
    int           mismatch_count;

    function new();
      ref_vel        = 16'd6000;
      undef_vel      = 16'd1500;
      trace_len      = 13'd4096;
      travel_acc     = '0;
      next_idx       = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        dtt_pkg::CFG_REF_VEL:   ref_vel = data;
        dtt_pkg::CFG_UNDEF_VEL: undef_vel = data;
        dtt_pkg::CFG_TRACE_LEN: trace_len = data[12:0];
        default: ;
      endcase
    endfunction

    // Advance travel time by one cell and queue the samples it covers
    function void take_cell(logic start, logic present, logic [15:0] vel, logic [15:0] tag);
      longint unsigned divisor, incr, total, limit, span_end, count;
      time_sample_t    s;
      if (start) begin
        travel_acc = '0;
        next_idx   = '0;
      end
      divisor = present ? vel : undef_vel;
      if (divisor == 0) divisor = 1;
      incr  = (64'(ref_vel) << FRAC_BITS) / divisor;
      total = 64'(travel_acc) + incr;
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      travel_acc = total[31:0];
      // round half up; time is never negative
      limit = (total + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      span_end = (trace_len > TRACE_DEPTH) ? TRACE_DEPTH : trace_len;
      if (limit < span_end) span_end = limit;
      count = (span_end > next_idx) ? span_end - next_idx : 0;
      s.clipped = (count > MAX_RUN);
      if (s.clipped) count = MAX_RUN;
      s.present = present;
      s.tag     = present ? tag : 16'd0;
      for (longint unsigned i = 0; i < count; i++) begin
        s.idx  = 12'(next_idx + i);
        s.last = (i + 1 == count);
        due_samples.insert(due_samples.size(), s);
      end
      next_idx = (limit > 8191) ? 13'd8191 : limit[12:0];
    endfunction

    function void note_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void match_sample(time_sample_t got);
      time_sample_t want;
      if (due_samples.size() == 0) begin
        $display("%0t: unexpected sample index %0d tag %0h", $time, got.idx, got.tag);
        mismatch_count++;
        return;
      end
      want = due_samples.pop_front();
      note_field("sample_index", want.idx, got.idx);
      note_field("out_present", want.present, got.present);
      note_field("out_tag", want.tag, got.tag);
      note_field("run_last", want.last, got.last);
      note_field("run_clipped", want.clipped, got.clipped);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] cell_velocity, [31:16] content_tag
  logic [1:0]  s_tuser;   // [0] trace_start, [1] cell_present
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [11:0] sample_index, [27:12] out_tag, [31:28] zero
  logic [1:0]  m_tuser;   // [0] out_present, [1] run_clipped
  logic        m_tlast;   // run_last

  int cell_gap_pct;
  int sink_stall_pct;

  resampled_trace model = new();

  depth_to_time_trace_resampler #(
    .TRACE_DEPTH(TRACE_DEPTH),
    .MAX_RUN    (MAX_RUN),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the sample stream at random on each falling edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check each sample transaction against the oldest prediction
  always @(posedge clk) begin
    time_sample_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.idx     = m_tdata[11:0];
      got.tag     = m_tdata[27:12];
      got.present = m_tuser[0];
      got.clipped = m_tuser[1];
      got.last    = m_tlast;
      model.match_sample(got);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    model.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] ref_v, logic [15:0] undef_v, logic [15:0] len);
    write_reg(dtt_pkg::CFG_REF_VEL, ref_v);
    write_reg(dtt_pkg::CFG_UNDEF_VEL, undef_v);
    write_reg(dtt_pkg::CFG_TRACE_LEN, len);
  endtask

  // Offer one depth cell, with random gaps ahead of it, and hold until taken
  task automatic send_cell(logic start, logic present, logic [15:0] vel, logic [15:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < cell_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tag, vel};
    s_tuser  <= {present, start};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    model.take_cell(start, present, vel, tag);
  endtask

  // Drop valid, wait for every predicted sample, then let the divider go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (model.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Velocities for short runs, some near the clip length, some tiny, others random
  function automatic logic [15:0] pick_velocity(int unsigned ref_v);
    int unsigned sel, v;
    sel = $urandom_range(99);
    if (sel < 45) v = (ref_v * 4) / $urandom_range(2, 28);
    else if (sel < 55) v = $urandom_range(0, 3);
    else if (sel < 65) v = ref_v / $urandom_range(55, 75);
    else v = $urandom_range(0, 65535);
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Random traces: each begins with a trace start, further starts now and then
  task automatic random_cells(int n);
    for (int i = 0; i < n; i++) begin
      send_cell((i == 0) || ($urandom_range(99) < 6), $urandom_range(99) < 80,
                pick_velocity(model.ref_vel), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = dtt_pkg::CFG_REF_VEL;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cell_gap_pct   = 6;
    sink_stall_pct = 61;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: exact sample steps, half rounding, empty cells, zero velocity,
    // a run of exactly MAX_RUN and one just over it
    send_cell(1'b1, 1'b1, 16'd6000, 16'hFFFF);
    send_cell(1'b0, 1'b1, 16'd12000, 16'h0000);
    send_cell(1'b0, 1'b1, 16'd24000, 16'h8001);
    send_cell(1'b0, 1'b0, 16'd65535, 16'h1234);
    send_cell(1'b0, 1'b1, 16'd65535, 16'hAAAA);
    send_cell(1'b0, 1'b1, 16'd0, 16'h5555);
    send_cell(1'b0, 1'b1, 16'd1500, 16'h00FF);
    send_cell(1'b1, 1'b1, 16'd94, 16'h0F0F);
    send_cell(1'b0, 1'b1, 16'd92, 16'hF0F0);
    send_cell(1'b1, 1'b0, 16'd0, 16'h0000);
    send_cell(1'b1, 1'b1, 16'd3, 16'hFFFF);
    settle();

    // largest reference: a clipped run, then travel time saturates
    set_regs(16'd65535, 16'd65535, 16'd4096);
    send_cell(1'b1, 1'b1, 16'd1, 16'hC3C3);
    send_cell(1'b0, 1'b1, 16'd1, 16'h3C3C);
    send_cell(1'b1, 1'b0, 16'd1, 16'h7777);
    settle();

    // zero reference velocity: time never moves
    write_reg(dtt_pkg::CFG_REF_VEL, 16'd0);
    send_cell(1'b1, 1'b1, 16'd100, 16'h1111);
    send_cell(1'b0, 1'b0, 16'd100, 16'h2222);
    settle();

    // zero trace length: every sample is suppressed
    set_regs(16'd6000, 16'd1500, 16'd0);
    send_cell(1'b1, 1'b1, 16'd6000, 16'h3333);
    settle();

    // smallest settings: one sample per trace, the rest falls past the end
    set_regs(16'd1, 16'd1, 16'd1);
    send_cell(1'b1, 1'b1, 16'd1, 16'h7FFF);
    send_cell(1'b0, 1'b0, 16'd1, 16'h4444);
    send_cell(1'b1, 1'b1, 16'd2, 16'h8000);
    settle();

    set_regs(16'd6000, 16'd1500, 16'd4096);
    random_cells(34);
    settle();

    cell_gap_pct   = 61;
    sink_stall_pct = 6;
    set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
             16'($urandom_range(1, 300)));
    random_cells(34);
    settle();

    cell_gap_pct   = 0;
    sink_stall_pct = 0;
    set_regs(16'($urandom_range(200, 20000)), 16'($urandom_range(1, 65535)), 16'd2048);
    random_cells(34);
    settle();

    if (model.mismatch_count == 0 && model.due_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== depth_to_time_trace_resampler.f =====
hdl/dtt_pkg.sv
hdl/dtt_fifo.sv
hdl/dtt_front.sv
hdl/dtt_back.sv
hdl/depth_to_time_trace_resampler.sv
tb/testbench.sv
